// ===== sv/wim256_pkg.sv =====
package wim256_pkg;

  localparam int unsigned LimbBits     = 32;
  localparam int unsigned OperandLimbs = 8;
  localparam int unsigned WordBits     = 64;
  localparam int unsigned InWords      = 4;
  localparam int unsigned OutWords     = 8;
  localparam int unsigned OpBits       = InWords * WordBits;
  localparam int unsigned ProdBits     = OutWords * WordBits;
  localparam int unsigned SpanBits     = OperandLimbs * LimbBits;
  localparam int unsigned AccBits      = 2 * SpanBits;
  localparam int unsigned NumCells     = 2 * OperandLimbs;
  localparam int unsigned CellIdxBits  = $clog2(NumCells);

  typedef logic [WordBits-1:0]    word_t;
  typedef logic [LimbBits-1:0]    limb_t;
  typedef logic [SpanBits-1:0]    span_t;
  typedef logic [AccBits-1:0]     acc_t;
  typedef logic [CellIdxBits-1:0] cell_idx_t;

  // Operand limbs as cut from the 256-bit words (bits past 255 read as zero)
  function automatic span_t to_span(input logic [OpBits-1:0] op);
    logic [OpBits+SpanBits-1:0] ext;
    ext = {{SpanBits{1'b0}}, op};
    return ext[SpanBits-1:0];
  endfunction

endpackage

// ===== sv/wim256_if.sv =====
interface wim256_in_if;
  logic            valid;
  logic            ready;
  wim256_pkg::word_t mcand_w0, mcand_w1, mcand_w2, mcand_w3;
  wim256_pkg::word_t mplier_w0, mplier_w1, mplier_w2, mplier_w3;
  modport source (output valid, mcand_w0, mcand_w1, mcand_w2, mcand_w3,
                  mplier_w0, mplier_w1, mplier_w2, mplier_w3, input ready);
  modport sink (input valid, mcand_w0, mcand_w1, mcand_w2, mcand_w3,
                mplier_w0, mplier_w1, mplier_w2, mplier_w3, output ready);
endinterface

interface wim256_out_if;
  logic            valid;
  logic            ready;
  wim256_pkg::word_t prod_w0, prod_w1, prod_w2, prod_w3;
  wim256_pkg::word_t prod_w4, prod_w5, prod_w6, prod_w7;
  modport source (output valid, prod_w0, prod_w1, prod_w2, prod_w3,
                  prod_w4, prod_w5, prod_w6, prod_w7, input ready);
  modport sink (input valid, prod_w0, prod_w1, prod_w2, prod_w3,
                prod_w4, prod_w5, prod_w6, prod_w7, output ready);
endinterface

// ===== sv/wim256_cell.sv =====
// One cell of the chain: folds one multiplicand limb row (eight 32 x 32 products)
// into the carry-save accumulator, then resolves product limb row_i with the
// ripple carry from the previous cell. Cells past the last limb add no row.
module wim256_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  wim256_pkg::span_t       mcand_i,
  input  wim256_pkg::span_t       mplier_i,
  input  wim256_pkg::acc_t        sum_i,
  input  wim256_pkg::acc_t        carry_i,
  input  logic                    cy_i,
  input  wim256_pkg::cell_idx_t   row_i,
  output logic                    valid_o,
  output wim256_pkg::span_t       mcand_o,
  output wim256_pkg::span_t       mplier_o,
  output wim256_pkg::acc_t        sum_o,
  output wim256_pkg::acc_t        carry_o,
  output logic                    cy_o
);
  localparam int unsigned RowBits = wim256_pkg::SpanBits + wim256_pkg::LimbBits;
  localparam int unsigned SelBits = $clog2(wim256_pkg::OperandLimbs);
  localparam int unsigned PpBits  = 2 * wim256_pkg::LimbBits;

  logic                     valid_q;
  wim256_pkg::span_t        mcand_q, mplier_q;
  wim256_pkg::acc_t         sum_q, sum_d, carry_q, carry_d;
  logic                     cy_q, cy_d;
  wim256_pkg::limb_t        limb;
  logic [SelBits-1:0]       sel;
  logic [PpBits-1:0]        pp;
  logic [RowBits-1:0]       lo_row, hi_row;
  wim256_pkg::acc_t         pp_lo, pp_hi, s1, c1, s2, c2;
  logic [wim256_pkg::LimbBits:0] col;

  // Row partial products: low halves at their limb, high halves one limb up
  always_comb begin
    sel    = row_i[SelBits-1:0];
    limb   = (row_i < wim256_pkg::cell_idx_t'(wim256_pkg::OperandLimbs)) ?
             mcand_i[sel*wim256_pkg::LimbBits +: wim256_pkg::LimbBits] : '0;
    lo_row = '0;
    hi_row = '0;
    pp     = '0;
    for (int j = 0; j < wim256_pkg::OperandLimbs; j++) begin
      pp = PpBits'(limb) *
           PpBits'(mplier_i[j*wim256_pkg::LimbBits +: wim256_pkg::LimbBits]);
      lo_row[j*wim256_pkg::LimbBits +: wim256_pkg::LimbBits] =
        pp[wim256_pkg::LimbBits-1:0];
      hi_row[(j+1)*wim256_pkg::LimbBits +: wim256_pkg::LimbBits] =
        pp[PpBits-1:wim256_pkg::LimbBits];
    end
    pp_lo = wim256_pkg::acc_t'(lo_row) << (row_i * wim256_pkg::LimbBits);
    pp_hi = wim256_pkg::acc_t'(hi_row) << (row_i * wim256_pkg::LimbBits);
  end

  // Two carry-save levels, then resolve this cell's product limb
  always_comb begin
    s1 = sum_i ^ carry_i ^ pp_lo;
    c1 = ((sum_i & carry_i) | (sum_i & pp_lo) | (carry_i & pp_lo)) << 1;
    s2 = s1 ^ c1 ^ pp_hi;
    c2 = ((s1 & c1) | (s1 & pp_hi) | (c1 & pp_hi)) << 1;
    col = {1'b0, s2[row_i*wim256_pkg::LimbBits +: wim256_pkg::LimbBits]} +
          {1'b0, c2[row_i*wim256_pkg::LimbBits +: wim256_pkg::LimbBits]} +
          {{wim256_pkg::LimbBits{1'b0}}, cy_i};
    sum_d   = s2;
    sum_d[row_i*wim256_pkg::LimbBits +: wim256_pkg::LimbBits] =
      col[wim256_pkg::LimbBits-1:0];
    carry_d = c2;
    carry_d[row_i*wim256_pkg::LimbBits +: wim256_pkg::LimbBits] = '0;
    cy_d    = col[wim256_pkg::LimbBits];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      sum_q    <= sum_d;
      carry_q  <= carry_d;
      cy_q     <= cy_d;
    end
  end

  assign valid_o  = valid_q;
  assign mcand_o  = mcand_q;
  assign mplier_o = mplier_q;
  assign sum_o    = sum_q;
  assign carry_o  = carry_q;
  assign cy_o     = cy_q;
endmodule

// ===== sv/wide_integer_multiplier_256_unit.sv =====
// 256 x 256 unsigned multiplier, full 512-bit product.
// Pipeline: one register stage per cell; cells 0..7 each add one 32-bit limb row in
// carry-save form and every cell resolves one 32-bit product limb.
// Throughput: one item per cycle; the chain advances whenever its last cell is
// empty or the output is taken, so a stall halts every cell together.
// Reset: rst_ni clears the valid flags of all cells; data registers are not reset.
module wide_integer_multiplier_256_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  wim256_in_if.sink    in_i,
  wim256_out_if.source out_o
);
  localparam int unsigned N  = wim256_pkg::NumCells;

  logic                  v     [N+1];
  wim256_pkg::span_t     a     [N+1];
  wim256_pkg::span_t     b     [N+1];
  wim256_pkg::acc_t      sum   [N+1];
  wim256_pkg::acc_t      carry [N+1];
  logic                  cy    [N+1];
  logic                  en;
  logic [wim256_pkg::ProdBits-1:0] prod;
  logic [wim256_pkg::AccBits+wim256_pkg::ProdBits-1:0] prod_ext;

  // Chain moves when the last cell is free or its item is taken
  assign en       = !v[N] || out_o.ready;
  assign in_i.ready = en;

  assign v[0]     = in_i.valid;
  assign a[0]     = wim256_pkg::to_span({in_i.mcand_w3, in_i.mcand_w2,
                                         in_i.mcand_w1, in_i.mcand_w0});
  assign b[0]     = wim256_pkg::to_span({in_i.mplier_w3, in_i.mplier_w2,
                                         in_i.mplier_w1, in_i.mplier_w0});
  assign sum[0]   = '0;
  assign carry[0] = '0;
  assign cy[0]    = 1'b0;

  for (genvar g = 0; g < N; g++) begin : g_row
    wim256_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (v[g]),
      .mcand_i  (a[g]),
      .mplier_i (b[g]),
      .sum_i    (sum[g]),
      .carry_i  (carry[g]),
      .cy_i     (cy[g]),
      .row_i    (wim256_pkg::cell_idx_t'(g)),
      .valid_o  (v[g+1]),
      .mcand_o  (a[g+1]),
      .mplier_o (b[g+1]),
      .sum_o    (sum[g+1]),
      .carry_o  (carry[g+1]),
      .cy_o     (cy[g+1])
    );
  end

  // Product words, bits beyond the limb span read as zero
  assign prod_ext = {{wim256_pkg::ProdBits{1'b0}}, sum[N]};
  assign prod     = prod_ext[wim256_pkg::ProdBits-1:0];

  assign out_o.valid   = v[N];
  assign out_o.prod_w0 = prod[63:0];
  assign out_o.prod_w1 = prod[127:64];
  assign out_o.prod_w2 = prod[191:128];
  assign out_o.prod_w3 = prod[255:192];
  assign out_o.prod_w4 = prod[319:256];
  assign out_o.prod_w5 = prod[383:320];
  assign out_o.prod_w6 = prod[447:384];
  assign out_o.prod_w7 = prod[511:448];
endmodule

// ===== tb/sv/wide_integer_multiplier_256_unit_tb.sv =====
`timescale 1ns / 1ps

module wide_integer_multiplier_256_unit_tb;

  typedef struct packed {
    wim256_pkg::word_t w7, w6, w5, w4, w3, w2, w1, w0;
  } product_t;

  // Scoreboard: holds expected products, checks each one that leaves the block
  class product_scoreboard;
    product_t pending[$];
    int       mismatches;
    int       reported;

    // Limb-by-limb schoolbook product, 32-bit limbs with a carry along each row
    function product_t multiply(logic [255:0] a, logic [255:0] b);
      logic [31:0]  ma [8];
      logic [31:0]  mb [8];
      logic [31:0]  acc [16];
      logic [63:0]  t;
      logic [31:0]  carry;
      logic [511:0] flat;
      for (int i = 0; i < 8; i++) begin
        ma[i] = a[i*32 +: 32];
        mb[i] = b[i*32 +: 32];
      end
      for (int k = 0; k < 16; k++) acc[k] = '0;
      for (int i = 0; i < 8; i++) begin
        carry = '0;
        for (int j = 0; j < 8; j++) begin
          t = 64'(ma[i]) * 64'(mb[j]) + 64'(acc[i+j]) + 64'(carry);
          acc[i+j] = t[31:0];
          carry = t[63:32];
        end
        acc[i+8] = carry;
      end
      for (int k = 0; k < 16; k++) flat[k*32 +: 32] = acc[k];
      return product_t'(flat);
    endfunction

    function void note_operands(logic [255:0] a, logic [255:0] b);
      pending.push_back(multiply(a, b));
    endfunction

    function void check_product(product_t got);
      product_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (reported < 10) begin
          reported++;
          $display("unexpected product %h", got);
        end
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (reported < 10) begin
          reported++;
          for (int w = 0; w < 8; w++)
            if (got[w*64 +: 64] !== want[w*64 +: 64])
              $display("prod_w%0d: expected %h, got %h", w, want[w*64 +: 64],
                       got[w*64 +: 64]);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;

  wim256_in_if  in_if  ();
  wim256_out_if out_if ();

  wide_integer_multiplier_256_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  product_scoreboard sb = new();

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Operand word with bias towards extremes and sparse patterns
  function automatic wim256_pkg::word_t rand_word();
    wim256_pkg::word_t w;
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = '1;
      2: w = wim256_pkg::word_t'(1) << $urandom_range(0, 63);
      3: w = {32'hFFFF_FFFF, $urandom()};
      4: w = {$urandom(), 32'hFFFF_FFFF};
      default: w = {$urandom(), $urandom()};
    endcase
    return w;
  endfunction

  // One item onto the input channel; burst gaps are inserted by the caller
  task automatic send_operands(logic [255:0] a, logic [255:0] b);
    in_if.valid     <= 1'b1;
    in_if.mcand_w0  <= a[63:0];
    in_if.mcand_w1  <= a[127:64];
    in_if.mcand_w2  <= a[191:128];
    in_if.mcand_w3  <= a[255:192];
    in_if.mplier_w0 <= b[63:0];
    in_if.mplier_w1 <= b[127:64];
    in_if.mplier_w2 <= b[191:128];
    in_if.mplier_w3 <= b[255:192];
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_operands(a, b);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(int n);
    in_if.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Receiver: phases of no stalls, light stalls and heavy stalls
  initial begin
    int mode;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 120)) begin
        @(negedge clk_i);
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 3) != 0);
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_product({out_if.prod_w7, out_if.prod_w6, out_if.prod_w5, out_if.prod_w4,
                        out_if.prod_w3, out_if.prod_w2, out_if.prod_w1, out_if.prod_w0});
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("wide_integer_multiplier_256_unit: mismatch");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    logic [255:0] a, b;
    int burst;
    in_if.valid = 1'b0;
    {in_if.mcand_w0, in_if.mcand_w1, in_if.mcand_w2, in_if.mcand_w3} = '0;
    {in_if.mplier_w0, in_if.mplier_w1, in_if.mplier_w2, in_if.mplier_w3} = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: zeros, ones, all-ones squared, single bits, carry ripples
    send_operands('0, '0);
    send_operands('1, '0);
    send_operands('0, '1);
    send_operands('1, '1);
    send_operands(256'd1, '1);
    send_operands('1, 256'd1);
    send_operands(256'd1 << 255, 256'd1 << 255);
    send_operands(256'hFFFF_FFFF, 256'hFFFF_FFFF);
    send_operands({8{32'h5555_5555}}, {8{32'hAAAA_AAAA}});
    send_operands({8{32'hAAAA_AAAA}}, {8{32'hAAAA_AAAA}});
    send_operands({128'h0, {128{1'b1}}}, {{128{1'b1}}, 128'h0});
    send_operands({{128{1'b1}}, 128'h0}, {{128{1'b1}}, 128'h0});
    send_operands({{128{1'b1}}, 128'h0}, {128'h0, {128{1'b1}}});
    send_operands({64'h0, {192{1'b1}}}, {64'h0, {192{1'b1}}});
    send_operands(256'd1 << 128, 256'd1 << 127);
    for (int k = 0; k < 8; k++)
      send_operands(256'hFFFF_FFFF << (32*k), '1);

    // Drain fully once before the random part
    pause_sender(0);
    while (sb.pending.size() != 0) @(negedge clk_i);
    @(negedge clk_i);

    // Random bursts
    for (int n = 0; n < 1900; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < 1900; k++, n++) begin
        a = {rand_word(), rand_word(), rand_word(), rand_word()};
        b = {rand_word(), rand_word(), rand_word(), rand_word()};
        send_operands(a, b);
      end
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 12));
      if (n > 900 && n <= 940) begin
        pause_sender(0);
        while (sb.pending.size() != 0) @(negedge clk_i);
        @(negedge clk_i);
      end
    end
    in_if.valid <= 1'b0;

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("wide_integer_multiplier_256_unit: match");
    else
      $display("wide_integer_multiplier_256_unit: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/wim256_pkg.sv
sv/wim256_if.sv
sv/wim256_cell.sv
sv/wide_integer_multiplier_256_unit.sv
tb/sv/wide_integer_multiplier_256_unit_tb.sv
